[src/pgs_pkg.sv]
// shared types and constants of the periodic grant scheduler
package pgs_pkg;

    localparam int MaxEntries = 16;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);
    localparam int ResultCap = 16;

    localparam logic [3:0] FixedMcs = 4'd4;
    localparam logic [3:0] FullWidth = 4'd12;
    localparam logic [13:0] ResetInterval = 14'd20;

    typedef enum logic [1:0] {
        OP_CONFIGURE  = 2'd0,
        OP_ACTIVATE   = 2'd1,
        OP_DEACTIVATE = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    // one classified request
    typedef struct packed {
        op_t         op;
        logic [15:0] ue_id;
        logic [13:0] interval_ms;
        logic [3:0]  subcarriers;
        logic [7:0]  available_rbs;
    } req_t;

    // one result item
    typedef struct packed {
        logic        grant_valid;
        logic [15:0] grant_ue;
        logic [3:0]  mcs;
        logic [7:0]  tb_size;
        logic [3:0]  grant_subcarriers;
        status_t     status;
        logic [6:0]  active_count;
        logic        last;
    } res_t;

    // transport size from subcarrier count, a small constant table
    function automatic logic [6:0] tbs_for(input logic [3:0] width);
        logic [6:0] t;
        case (width)
            4'd0, 4'd1, 4'd2: t = 7'd16;
            4'd3:  t = 7'd22;
            4'd4:  t = 7'd29;
            4'd5:  t = 7'd36;
            4'd6:  t = 7'd44;
            4'd7:  t = 7'd51;
            4'd8:  t = 7'd58;
            4'd9:  t = 7'd66;
            4'd10: t = 7'd73;
            4'd11: t = 7'd80;
            default: t = 7'd88;
        endcase
        return t;
    endfunction

endpackage

[src/pgs_front.sv]
// input side: accepts requests into a short queue
module pgs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pgs_pkg::req_t   s_req,
    output logic            q_valid,
    input  logic            q_pop,
    output pgs_pkg::req_t   q_req
);
    pgs_pkg::req_t mem_reg [2];
    logic [1:0] wr_reg, rd_reg, wr_next, rd_next;
    logic push;

    assign s_tready = (wr_reg - rd_reg) != 2'd2;
    assign push = s_tvalid && s_tready;
    assign q_valid = wr_reg != rd_reg;
    assign q_req = mem_reg[rd_reg[0]];
    assign wr_next = wr_reg + {1'b0, push};
    assign rd_next = rd_reg + {1'b0, q_pop && q_valid};

    // pointer update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg[0]] <= s_req;
        end
    end
endmodule

[src/pgs_back.sv]
// execution side: table, insert shift, tick scan and output register
module pgs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  pgs_pkg::req_t         q_req,
    input  logic [13:0]           default_interval,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output pgs_pkg::res_t         m_res
);
    localparam int N = pgs_pkg::MaxEntries;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_WRITE  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    logic [N-1:0] valid_reg, active_reg;
    logic [15:0] user_reg [N];
    logic [13:0] period_reg [N];
    logic [3:0] width_reg [N];
    logic [6:0] tbs_reg [N];
    logic [31:0] due_reg [N];
    logic [31:0] now_reg;
    logic [pgs_pkg::IdxW-1:0] pos_reg;
    logic [pgs_pkg::IdxW:0] scan_reg;
    logic [4:0] grants_reg;
    logic out_valid_reg;
    pgs_pkg::res_t out_reg;
    pgs_pkg::res_t pend_reg;
    pgs_pkg::req_t req_reg;

    // lookup of the request id over the table
    logic [N-1:0] hit;
    logic [N-1:0] greater;
    logic found;
    logic [pgs_pkg::IdxW-1:0] hit_idx, ins_idx;
    logic [pgs_pkg::CntW-1:0] used;
    logic [6:0] act_cnt;
    always_comb begin
        hit_idx = '0;
        ins_idx = '0;
        found = 1'b0;
        used = '0;
        act_cnt = '0;
        for (int i = 0; i < N; i++) begin
            hit[i] = valid_reg[i] && user_reg[i] == req_reg.ue_id;
            greater[i] = valid_reg[i] && user_reg[i] > req_reg.ue_id;
            used = used + pgs_pkg::CntW'(valid_reg[i]);
            act_cnt = act_cnt + 7'(valid_reg[i] && active_reg[i]);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = pgs_pkg::IdxW'(i);
                found = 1'b1;
            end
        end
        ins_idx = used[pgs_pkg::IdxW-1:0];
        for (int i = N - 1; i >= 0; i--) begin
            if (greater[i]) ins_idx = pgs_pkg::IdxW'(i);
        end
    end

    logic full;
    assign full = used == pgs_pkg::CntW'(N);
    assign q_pop = state_reg == S_IDLE && q_valid && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_res = out_reg;

    // current scan slot
    logic [pgs_pkg::IdxW-1:0] si;
    logic [31:0] diff;
    logic due_now;
    assign si = scan_reg[pgs_pkg::IdxW-1:0];
    assign diff = now_reg - due_reg[si];
    assign due_now = valid_reg[si] && active_reg[si] && !diff[31];

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        logic out_valid_next;
        pgs_pkg::res_t last_res;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            active_reg <= '0;
            now_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        req_reg <= q_req;
                        scan_reg <= '0;
                        grants_reg <= '0;
                        state_reg <= (q_req.op == pgs_pkg::OP_TICK) ? S_SCAN : S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // classify and make room for a new entry
                    if (req_reg.op == pgs_pkg::OP_DEACTIVATE) begin
                        if (found) active_reg[hit_idx] <= 1'b0;
                        out_reg <= '{default: '0,
                            status: found ? pgs_pkg::ST_OK : pgs_pkg::ST_UNKNOWN,
                            active_count: act_cnt - 7'(found && active_reg[hit_idx]),
                            last: 1'b1};
                        out_valid_next = 1'b1;
                        state_reg <= S_IDLE;
                    end else if (found) begin
                        pos_reg <= hit_idx;
                        state_reg <= S_WRITE;
                    end else if (full) begin
                        out_reg <= '{default: '0, status: pgs_pkg::ST_FULL,
                            active_count: act_cnt, last: 1'b1};
                        out_valid_next = 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        for (int i = N - 1; i > 0; i--) begin
                            if (pgs_pkg::IdxW'(i) > ins_idx) begin
                                valid_reg[i] <= valid_reg[i-1];
                                active_reg[i] <= active_reg[i-1];
                                user_reg[i] <= user_reg[i-1];
                                period_reg[i] <= period_reg[i-1];
                                width_reg[i] <= width_reg[i-1];
                                tbs_reg[i] <= tbs_reg[i-1];
                                due_reg[i] <= due_reg[i-1];
                            end
                        end
                        pos_reg <= ins_idx;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    // fill the entry, activate keeps an existing entry's setup
                    if (out_free) begin
                        valid_reg[pos_reg] <= 1'b1;
                        due_reg[pos_reg] <= now_reg;
                        if (req_reg.op == pgs_pkg::OP_CONFIGURE) begin
                            active_reg[pos_reg] <= 1'b0;
                            user_reg[pos_reg] <= req_reg.ue_id;
                            period_reg[pos_reg] <= req_reg.interval_ms;
                            width_reg[pos_reg] <= req_reg.subcarriers;
                            tbs_reg[pos_reg] <= pgs_pkg::tbs_for(req_reg.subcarriers);
                        end else begin
                            active_reg[pos_reg] <= 1'b1;
                            if (!found) begin
                                user_reg[pos_reg] <= req_reg.ue_id;
                                period_reg[pos_reg] <= default_interval;
                                width_reg[pos_reg] <= pgs_pkg::FullWidth;
                                tbs_reg[pos_reg] <= pgs_pkg::tbs_for(pgs_pkg::FullWidth);
                            end
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // count taken after the write settled
                    out_reg <= '{default: '0, status: pgs_pkg::ST_OK,
                        active_count: act_cnt, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN: begin
                    // one slot per cycle unless a due slot waits on a stalled output, a found grant waits in pend_reg
                    if (scan_reg == (pgs_pkg::IdxW+1)'(N)
                        || {3'b0, grants_reg} >= req_reg.available_rbs
                        || grants_reg == 5'(pgs_pkg::ResultCap)) begin
                        if (out_free) begin
                            if (grants_reg == '0) begin
                                out_reg <= '{default: '0, status: pgs_pkg::ST_OK,
                                    active_count: act_cnt, last: 1'b1};
                            end else begin
                                last_res = pend_reg;
                                last_res.last = 1'b1;
                                out_reg <= last_res;
                            end
                            out_valid_next = 1'b1;
                            now_reg <= now_reg + 32'd1;
                            state_reg <= S_IDLE;
                        end
                    end else if (!due_now) begin
                        scan_reg <= scan_reg + 1'b1;
                    end else if (grants_reg == '0 || out_free) begin
                        // a newer grant exists, so the pending one is not the last
                        if (grants_reg != '0) begin
                            out_reg <= pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_reg <= '{grant_valid: 1'b1, grant_ue: user_reg[si],
                            mcs: pgs_pkg::FixedMcs, tb_size: {1'b0, tbs_reg[si]},
                            grant_subcarriers: width_reg[si],
                            status: pgs_pkg::ST_OK, active_count: act_cnt,
                            last: 1'b0};
                        due_reg[si] <= now_reg + {18'b0, period_reg[si]};
                        grants_reg <= grants_reg + 5'd1;
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[src/periodic_grant_scheduler.sv]
// top level of the periodic grant scheduler
// channel | dir | handshake     | payload
// s_      | in  | tvalid/tready | tuser: op; tdata: ue_id, interval_ms, subcarriers, available_rbs
// m_      | out | tvalid/tready | tdata + tuser + tlast
// apb     | in  | psel/penable  | default_interval_ms at address 0
// a request is registered into a two-entry queue and popped by the back end when idle with no result waiting
// configure/activate: S_SHIFT, S_WRITE, S_EMIT, then the output register; deactivate or full table: S_SHIFT only
// a tick scans one slot per cycle unless a due slot waits on a stalled output
// a found grant waits in a pending register until the next grant or the end is found
// reset is synchronous; the table needs no clearing pass
// output stalls hold the scan; the queue takes up to two more requests meanwhile
module periodic_grant_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // ue_id, interval_ms, subcarriers, available_rbs
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // grant_ue, mcs, tb_size, grant_subcarriers, active_count
    output logic [2:0]  m_tuser,   // grant_valid, status
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [13:0] interval_reg;
    pgs_pkg::req_t s_req, q_req;
    pgs_pkg::res_t res;
    logic q_valid, q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {18'b0, interval_reg} : 32'b0;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) interval_reg <= pgs_pkg::ResetInterval;
        else if (psel && penable && pwrite && paddr == 2'd0) interval_reg <= pwdata[13:0];
    end

    assign s_req.op = pgs_pkg::op_t'(s_tuser);
    assign s_req.ue_id = s_tdata[15:0];
    assign s_req.interval_ms = s_tdata[29:16];
    assign s_req.subcarriers = s_tdata[33:30];
    assign s_req.available_rbs = s_tdata[41:34];

    pgs_front u_front (.aclk, .aresetn, .s_tvalid, .s_tready, .s_req,
                       .q_valid, .q_pop, .q_req);

    pgs_back u_back (.aclk, .aresetn, .q_valid, .q_pop, .q_req,
                     .default_interval(interval_reg), .m_tvalid, .m_tready, .m_res(res));

    assign m_tdata = {1'b0, res.active_count, res.grant_subcarriers, res.tb_size,
                      res.mcs, res.grant_ue};
    assign m_tuser = {res.status, res.grant_valid};
    assign m_tlast = res.last;

    // assertions
    logic unused_hi;
    assign unused_hi = ^s_tdata[47:42];

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.active_count <= 7'(pgs_pkg::MaxEntries))
        else $error("active count above table size");
    a_nograntfields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res.grant_valid) |-> (res.grant_ue == 16'd0 && res.last))
        else $error("empty result carries grant data");
    a_grantmcs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.grant_valid) |-> res.mcs == pgs_pkg::FixedMcs)
        else $error("grant mcs wrong");
endmodule

[test/pgs_checker.sv]
// request and result monitor with grant prediction for the periodic grant scheduler
`timescale 1ns / 100ps

module pgs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // ue_id, interval_ms, subcarriers, available_rbs
    input  logic [1:0]  s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // grant_ue, mcs, tb_size, grant_subcarriers, active_count
    input  logic [2:0]  m_tuser,   // grant_valid, status
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          request_total,
    output int          grant_total
);

    localparam int Slots = 16;

    // shadow of the grant table
    logic        tab_valid [Slots];
    logic        tab_active[Slots];
    logic [15:0] tab_user  [Slots];
    logic [13:0] tab_period[Slots];
    logic [3:0]  tab_width [Slots];
    logic [7:0]  tab_tbs   [Slots];
    logic [31:0] tab_due   [Slots];
    logic [31:0] clock_ms;
    logic [13:0] default_period;
    pgs_pkg::res_t grant_queue[$];

    assign pending = grant_queue.size();

    // transport size: 88 scaled by width/12, floor of 16
    function automatic logic [7:0] size_for(input logic [3:0] width);
        int t;
        if (width >= 4'd12) return 8'd88;
        t = (88 * int'(width)) / 12;
        if (t < 16) t = 16;
        return 8'(t);
    endfunction

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < Slots; i++) if (tab_valid[i]) n++;
        return n;
    endfunction

    function automatic logic [6:0] active_users();
        int n;
        n = 0;
        for (int i = 0; i < Slots; i++) if (tab_valid[i] && tab_active[i]) n++;
        return 7'(n);
    endfunction

    // position of a user, or -1; ins gets the sorted insertion point
    function automatic int lookup(input logic [15:0] id, output int ins);
        int n;
        n = used_slots();
        for (int i = 0; i < n; i++) begin
            if (tab_user[i] == id) begin
                ins = i;
                return i;
            end
            if (tab_user[i] > id) begin
                ins = i;
                return -1;
            end
        end
        ins = n;
        return -1;
    endfunction

    // write an inactive entry due now, -1 when the table is full
    function automatic int store_entry(input logic [15:0] id, input logic [13:0] period,
                                       input logic [3:0] width);
        int ins;
        int idx;
        int n;
        idx = lookup(id, ins);
        if (idx < 0) begin
            n = used_slots();
            if (n >= Slots) return -1;
            for (int i = n; i > ins; i--) begin
                tab_valid[i]  = tab_valid[i-1];
                tab_active[i] = tab_active[i-1];
                tab_user[i]   = tab_user[i-1];
                tab_period[i] = tab_period[i-1];
                tab_width[i]  = tab_width[i-1];
                tab_tbs[i]    = tab_tbs[i-1];
                tab_due[i]    = tab_due[i-1];
            end
            idx = ins;
        end
        tab_valid[idx]  = 1'b1;
        tab_active[idx] = 1'b0;
        tab_user[idx]   = id;
        tab_period[idx] = period;
        tab_width[idx]  = width;
        tab_tbs[idx]    = size_for(width);
        tab_due[idx]    = clock_ms;
        return idx;
    endfunction

    function automatic void add_result(input logic gv, input logic [15:0] ue,
                                       input logic [3:0] mcs, input logic [7:0] tbs,
                                       input logic [3:0] width, input pgs_pkg::status_t st);
        pgs_pkg::res_t r;
        r.grant_valid       = gv;
        r.grant_ue          = ue;
        r.mcs               = mcs;
        r.tb_size           = tbs;
        r.grant_subcarriers = width;
        r.status            = st;
        r.active_count      = active_users();
        r.last              = 1'b0;
        grant_queue = {grant_queue, r};
    endfunction

    // expected results of one request
    function automatic void predict_request(input pgs_pkg::req_t rq);
        pgs_pkg::status_t st;
        int idx;
        int ins;
        int k;
        st = pgs_pkg::ST_OK;
        case (rq.op)
            pgs_pkg::OP_CONFIGURE: begin
                if (store_entry(rq.ue_id, rq.interval_ms, rq.subcarriers) < 0)
                    st = pgs_pkg::ST_FULL;
            end
            pgs_pkg::OP_ACTIVATE: begin
                idx = lookup(rq.ue_id, ins);
                if (idx < 0) idx = store_entry(rq.ue_id, default_period, 4'd12);
                if (idx < 0) begin
                    st = pgs_pkg::ST_FULL;
                end else begin
                    tab_active[idx] = 1'b1;
                    tab_due[idx]    = clock_ms;
                end
            end
            pgs_pkg::OP_DEACTIVATE: begin
                idx = lookup(rq.ue_id, ins);
                if (idx < 0) st = pgs_pkg::ST_UNKNOWN;
                else tab_active[idx] = 1'b0;
            end
            default: begin
                k = 0;
                for (int i = 0; i < Slots; i++) begin
                    logic [31:0] gap;
                    if (k >= int'(rq.available_rbs) || k >= 16) break;
                    if (!tab_valid[i] || !tab_active[i]) continue;
                    gap = clock_ms - tab_due[i];
                    if (gap[31]) continue;
                    add_result(1'b1, tab_user[i], 4'd4, tab_tbs[i], tab_width[i],
                               pgs_pkg::ST_OK);
                    tab_due[i] = clock_ms + 32'(tab_period[i]);
                    k++;
                end
                clock_ms = clock_ms + 32'd1;
                grant_total += k;
                if (k > 0) begin
                    grant_queue[grant_queue.size()-1].last = 1'b1;
                    return;
                end
            end
        endcase
        add_result(1'b0, 16'd0, 4'd0, 8'd0, 4'd0, st);
        grant_queue[grant_queue.size()-1].last = 1'b1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: result %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // sample both channels and the register port
    always @(posedge aclk) begin
        pgs_pkg::res_t want;
        pgs_pkg::req_t rq;
        if (!aresetn) begin
            for (int i = 0; i < Slots; i++) begin
                tab_valid[i]  = 1'b0;
                tab_active[i] = 1'b0;
            end
            clock_ms       = 32'd0;
            default_period = 14'd20;
            grant_queue.delete();
            fail_count    = 0;
            request_total = 0;
            grant_total   = 0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) default_period = pwdata[13:0];
            if (s_tvalid && s_tready) begin
                rq.op            = pgs_pkg::op_t'(s_tuser);
                rq.ue_id         = s_tdata[15:0];
                rq.interval_ms   = s_tdata[29:16];
                rq.subcarriers   = s_tdata[33:30];
                rq.available_rbs = s_tdata[41:34];
                request_total++;
                predict_request(rq);
            end
            if (m_tvalid && m_tready) begin
                if (grant_queue.size() == 0) begin
                    report("unexpected", 32'(m_tdata), 32'd0);
                end else begin
                    want = grant_queue.pop_front();
                    if (m_tuser[0] !== want.grant_valid)
                        report("grant_valid", 32'(m_tuser[0]), 32'(want.grant_valid));
                    if (m_tdata[15:0] !== want.grant_ue)
                        report("grant_ue", 32'(m_tdata[15:0]), 32'(want.grant_ue));
                    if (m_tdata[19:16] !== want.mcs)
                        report("mcs", 32'(m_tdata[19:16]), 32'(want.mcs));
                    if (m_tdata[27:20] !== want.tb_size)
                        report("tb_size", 32'(m_tdata[27:20]), 32'(want.tb_size));
                    if (m_tdata[31:28] !== want.grant_subcarriers)
                        report("subcarriers", 32'(m_tdata[31:28]),
                               32'(want.grant_subcarriers));
                    if (m_tuser[2:1] !== want.status)
                        report("status", 32'(m_tuser[2:1]), 32'(want.status));
                    if (m_tdata[38:32] !== want.active_count)
                        report("active_count", 32'(m_tdata[38:32]), 32'(want.active_count));
                    if (m_tlast !== want.last)
                        report("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

endmodule

[test/tb.sv]
// stimulus and verdict for the periodic grant scheduler
`timescale 1ns / 100ps

module tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // ue_id, interval_ms, subcarriers, available_rbs
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // grant_ue, mcs, tb_size, grant_subcarriers, active_count
    logic [2:0]  m_tuser;   // grant_valid, status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int request_total;
    int grant_total;
    int burst_left = 0;
    int stall_cnt = 0;
    logic [15:0] id_pool[10];

    periodic_grant_scheduler u_dut (.*);

    pgs_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata,
        .fail_count, .pending, .request_total, .grant_total
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver: stretches of full readiness alternate with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if ((stall_cnt / 150) % 3 == 0) m_tready <= 1'b1;
            else if ((stall_cnt / 150) % 3 == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 7) == 0);
        end
    end

    // one request, sent in bursts with random gaps
    task automatic send_req(input pgs_pkg::op_t op, input logic [15:0] id,
                            input logic [13:0] period, input logic [3:0] width,
                            input logic [7:0] rbs);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, rbs, width, period, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [13:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(input int count, input bit fresh_ids);
        pgs_pkg::op_t op;
        logic [15:0] id;
        logic [13:0] period;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            op = pick < 45 ? pgs_pkg::OP_TICK : pick < 70 ? pgs_pkg::OP_ACTIVATE :
                 pick < 85 ? pgs_pkg::OP_CONFIGURE : pgs_pkg::OP_DEACTIVATE;
            id = (fresh_ids && $urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                          : id_pool[$urandom_range(0, 9)];
            period = $urandom_range(0, 9) < 7 ? 14'($urandom_range(0, 6))
                                              : 14'($urandom_range(0, 16383));
            send_req(op, id, period, 4'($urandom_range(0, 15)),
                     $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 20)));
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        for (int i = 0; i < 10; i++) id_pool[i] = 16'($urandom_range(1, 65534));
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and corner cases
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd255);
        send_req(pgs_pkg::OP_DEACTIVATE, 16'hffff, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_CONFIGURE, 16'hffff, 14'h3fff, 4'd15, 8'hff);
        send_req(pgs_pkg::OP_CONFIGURE, 16'd0, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_CONFIGURE, 16'h5555, 14'd1, 4'd1, 8'd0);
        send_req(pgs_pkg::OP_CONFIGURE, 16'haaaa, 14'd2, 4'd12, 8'd0);
        send_req(pgs_pkg::OP_CONFIGURE, 16'haaaa, 14'd3, 4'd13, 8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, 16'h5555, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, 16'd0, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, 16'haaaa, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, id_pool[0], 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd2);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd255);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd255);
        send_req(pgs_pkg::OP_DEACTIVATE, 16'd0, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, 16'hffff, 14'd0, 4'd0, 8'd0);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd255);
        drain();

        // interval register writes between phases
        write_interval(14'd1);
        random_phase(35, 1'b0);
        drain();
        write_interval(14'd10240);
        random_phase(30, 1'b0);
        drain();
        write_interval(14'($urandom_range(1, 10240)));

        // fill the table, then overflow it
        for (int i = 0; i < 10; i++)
            send_req(pgs_pkg::OP_ACTIVATE, id_pool[i], 14'd0, 4'd0, 8'd0);
        for (int i = 0; i < 8; i++)
            send_req(pgs_pkg::OP_CONFIGURE, 16'($urandom_range(0, 65535)), 14'd1, 4'd5,
                     8'd0);
        send_req(pgs_pkg::OP_ACTIVATE, 16'($urandom_range(0, 65535)), 14'd0, 4'd0, 8'd0);
        for (int i = 0; i < 16; i++)
            send_req(pgs_pkg::OP_ACTIVATE, 16'($urandom_range(0, 65535)), 14'd0, 4'd0,
                     8'd0);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd255);
        send_req(pgs_pkg::OP_TICK, 16'd0, 14'd0, 4'd0, 8'd7);
        drain();
        write_interval(14'd20);
        random_phase(50, 1'b1);

        // wait out the last results
        drain();
        $display("covered %0d requests and %0d grants, table filled and overflowed",
                 request_total, grant_total);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
